// ===== rtl/smq_pkg.sv =====
// Shared types and constants for the stepper move queue.
// No dependencies.
`default_nettype none
package smq_pkg;

  localparam logic [2:0] KIND_LINE    = 3'd0;
  localparam logic [2:0] KIND_DWELL   = 3'd1;
  localparam logic [2:0] KIND_MARKER  = 3'd2;
  localparam logic [2:0] KIND_DEQUEUE = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [4:0] TYPE_LINE   = 5'd0;
  localparam logic [4:0] TYPE_DWELL  = 5'd1;
  localparam logic [4:0] TYPE_MARKER = 5'd2;

  localparam int TICK_W = 40;
  localparam int DIV_STEPS = 2;  // quotient bits per cycle

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] steps_x_in;
    logic signed [31:0] steps_y_in;
    logic signed [31:0] steps_z_in;
    logic [31:0]        duration_us;
    logic [3:0]         marker_code;
  } smq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_kind;
    logic [1:0]  axis_index;
    logic [30:0] axis_steps;
    logic        axis_direction;
    logic [15:0] axis_period;
    logic [24:0] axis_postscale;
    logic        last;
    logic        queue_full;
  } smq_out_t;

  typedef struct packed {
    logic [30:0] steps;
    logic        dir;
    logic [15:0] period;
    logic [24:0] post;
  } smq_axis_t;

endpackage
`default_nettype wire

// ===== rtl/smq_lane.sv =====
// One axis lane: magnitude, restoring divide of ticks by steps, normalization.
// Uses smq_pkg.
`default_nettype none
module smq_lane
  import smq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       raw,
  input  wire logic [TICK_W-1:0] ticks,
  output logic                   done,
  output smq_axis_t              result
);
  localparam int CNT_W = $clog2(TICK_W / DIV_STEPS + 1);
  typedef enum logic [1:0] {IDLE, DIV, NORM} st_t;

  st_t               st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TICK_W-1:0] q_r;
  logic [31:0]       rem_r;
  logic [30:0]       den_r;
  logic              dir_r;
  logic [24:0]       post_r;
  logic              active_r;
  logic              done_r;

  logic [30:0] mag;
  logic [TICK_W-1:0] q_nxt;
  logic [31:0] rem_nxt;

  always_comb begin
    logic [31:0] neg;
    neg = 32'd0 - raw;
    if (raw[31]) mag = neg[31] ? 31'h7FFFFFFF : neg[30:0];
    else mag = raw[30:0];
  end

  always_comb begin
    logic [32:0] t;
    q_nxt = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {rem_nxt, q_nxt[TICK_W-1]};
      q_nxt = {q_nxt[TICK_W-2:0], 1'b0};
      if (t >= {2'b00, den_r}) begin
        t = t - {2'b00, den_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = t[31:0];
    end
  end

  // done stays high from the end of normalization until the next start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      case (st_r)
        IDLE: if (start) begin
          active_r <= (raw != 32'd0);
          dir_r <= raw[31];
          den_r <= (raw == 32'd0) ? 31'd1 : mag;
          q_r <= ticks;
          rem_r <= '0;
          post_r <= 25'd1;
          cnt_r <= '0;
          done_r <= 1'b0;
          st_r <= DIV;
        end
        DIV: begin
          q_r <= q_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TICK_W / DIV_STEPS - 1)) st_r <= NORM;
        end
        NORM: begin
          if (q_r[TICK_W-1:16] != '0) begin
            q_r <= {1'b0, q_r[TICK_W-1:1]};
            post_r <= {post_r[23:0], 1'b0};
          end else begin
            done_r <= 1'b1;
            st_r <= IDLE;
          end
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign result = active_r ?
                  '{steps: den_r, dir: dir_r, period: q_r[15:0], post: post_r} : '0;
endmodule
`default_nettype wire

// ===== rtl/stepper_move_queue_precompute.sv =====
// Stepper move queue: three timing lanes merged into a ring of entries.
// Uses smq_pkg and smq_lane.
`default_nettype none
// Each command word is taken when start is high and busy low; busy stays high
// until the cycle in which the word's last result is presented. Line and
// dwell words run three lanes, one per axis, each a 40-bit divide at two
// quotient bits a cycle followed by normalize shifts, one a cycle, until the
// quotient fits in 16 bits; the single result follows the STORE and REPLY
// states once the slowest lane is done. Markers, flush, unused kinds and
// rejected words pass from CALC straight to REPLY; a dequeue from a non-empty
// queue gives its X, Y, Z results on consecutive cycles from the DEQ state.
// Results are strobed by out_valid for one cycle and cannot be held off.
module stepper_move_queue_precompute
  import smq_pkg::*;
#(
  parameter int QUEUE_SLOTS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire smq_in_t in_word,
  output logic      out_valid,
  output smq_out_t  out_word,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  localparam int IW = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  typedef enum logic [2:0] {IDLE, CALC, WAIT, STORE, REPLY, DEQ} st_t;

  st_t st_r;
  logic [7:0] tpu_r;
  logic [IW-1:0] wr_r, rd_r, slot_r;
  logic [1:0] ax_r;
  smq_in_t in_r;
  smq_out_t out_r;
  logic out_valid_r;
  logic [1:0] status_r;

  logic [4:0] types_r [QUEUE_SLOTS];
  smq_axis_t axes_r [QUEUE_SLOTS][3];

  logic [TICK_W-1:0] ticks_r;
  logic lane_start_r;
  logic [2:0] lane_done;
  smq_axis_t lane_res [3];
  logic [31:0] lane_raw [3];

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    return (32'(i) + 1 >= QUEUE_SLOTS) ? '0 : i + 1'b1;
  endfunction

  function automatic smq_out_t reply_word(input logic [1:0] st, input logic fl);
    smq_out_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    o.queue_full = fl;
    return o;
  endfunction

  function automatic smq_out_t deq_word(input logic [4:0] ty, input logic [1:0] ax,
                                        input smq_axis_t e, input logic fl);
    smq_out_t o;
    o = '0;
    o.status = ST_OK;
    o.entry_kind = ty;
    o.axis_index = ax;
    o.axis_steps = e.steps;
    o.axis_direction = e.dir;
    o.axis_period = e.period;
    o.axis_postscale = e.post;
    o.last = (ax == 2'd2);
    o.queue_full = fl;
    return o;
  endfunction

  logic full;
  assign full = (nxt(wr_r) == rd_r);

  always_comb begin
    lane_raw[0] = in_r.steps_x_in;
    lane_raw[1] = in_r.steps_y_in;
    lane_raw[2] = in_r.steps_z_in;
    if (in_r.kind == KIND_DWELL) begin
      lane_raw[0] = 32'd0;
      lane_raw[1] = 32'd0;
      lane_raw[2] = 32'd1;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    smq_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(lane_start_r), .raw(lane_raw[g]),
      .ticks(ticks_r), .done(lane_done[g]), .result(lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tpu_r <= 8'd32;
    else if (cfg_we) tpu_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE;
      wr_r <= '0;
      rd_r <= '0;
      out_valid_r <= 1'b0;
      lane_start_r <= 1'b0;
    end else begin
      out_valid_r <= (st_r == REPLY) || (st_r == DEQ);
      lane_start_r <= (st_r == CALC) && (in_r.kind <= KIND_DWELL) && !full;
      case (st_r)
        IDLE: if (start) begin
          in_r <= in_word;
          slot_r <= wr_r;
          ticks_r <= {8'd0, in_word.duration_us} * {32'd0, tpu_r};
          st_r <= CALC;
        end
        CALC: begin
          if (in_r.kind <= KIND_MARKER && full) begin
            status_r <= ST_FULL;
            st_r <= REPLY;
          end else if (in_r.kind == KIND_MARKER) begin
            types_r[slot_r] <= TYPE_MARKER + {1'b0, in_r.marker_code};
            for (int a = 0; a < 3; a++) axes_r[slot_r][a] <= '0;
            wr_r <= nxt(slot_r);
            status_r <= ST_OK;
            st_r <= REPLY;
          end else if (in_r.kind <= KIND_DWELL) begin
            status_r <= ST_OK;
            st_r <= WAIT;
          end else if (in_r.kind == KIND_DEQUEUE && wr_r == rd_r) begin
            status_r <= ST_EMPTY;
            st_r <= REPLY;
          end else if (in_r.kind == KIND_DEQUEUE) begin
            ax_r <= 2'd0;
            slot_r <= rd_r;
            rd_r <= nxt(rd_r);
            st_r <= DEQ;
          end else begin
            if (in_r.kind == KIND_FLUSH) rd_r <= wr_r;
            status_r <= ST_OK;
            st_r <= REPLY;
          end
        end
        // done flags of the previous word are still up while start is in flight
        WAIT: if (!lane_start_r && (&lane_done)) st_r <= STORE;
        STORE: begin
          types_r[slot_r] <= (in_r.kind == KIND_DWELL) ? TYPE_DWELL : TYPE_LINE;
          for (int a = 0; a < 3; a++) axes_r[slot_r][a] <= lane_res[a];
          wr_r <= nxt(slot_r);
          st_r <= REPLY;
        end
        REPLY: begin
          out_r <= reply_word(status_r, full);
          st_r <= IDLE;
        end
        DEQ: begin
          out_r <= deq_word(types_r[slot_r], ax_r, axes_r[slot_r][ax_r], full);
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) st_r <= IDLE;
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  assign busy = (st_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |=> !out_valid) else $error("stray result");
  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (lane_done[1] || lane_done[2] || st_r == WAIT))
    else $error("lane done outside wait");
endmodule
`default_nettype wire

// ===== sim/stepper_move_queue_precompute_tb.sv =====
// Self-checking bench for the stepper move queue with per-axis precompute.
// Needs smq_pkg and stepper_move_queue_precompute; predicts every result word.
module stepper_move_queue_precompute_tb;
  import smq_pkg::*;

  localparam int SLOTS = 4;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  smq_in_t in_word;
  logic out_valid;
  smq_out_t out_word;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  stepper_move_queue_precompute #(.QUEUE_SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predicted queue contents
  logic [7:0]  tick_rate;
  logic [4:0]  slot_type [SLOTS];
  smq_axis_t   slot_axis [SLOTS][3];
  int unsigned wr_ptr, rd_ptr;

  smq_in_t  pending_words[$];
  smq_out_t expected_words[$];
  int mismatches, words_seen, words_sent, dequeues_ok;
  int gap;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("stepper_move_queue_precompute_tb NOT OK");
    $finish;
  end

  function automatic int unsigned wrap(int unsigned i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  function automatic smq_axis_t axis_timing(logic [39:0] ticks, logic [30:0] mag,
                                            logic dir);
    smq_axis_t a;
    logic [63:0] q;
    logic [24:0] post;
    q = {24'd0, ticks} / {33'd0, mag};
    post = 1;
    while (q[63:16] != 0) begin
      q = q >> 1;
      post = post << 1;
    end
    a.steps = mag;
    a.dir = dir;
    a.period = q[15:0];
    a.post = post;
    return a;
  endfunction

  function automatic smq_out_t status_word(logic [1:0] st);
    smq_out_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    o.queue_full = (wrap(wr_ptr) == rd_ptr);
    return o;
  endfunction

  // Advances the predicted queue by one command word and queues its results.
  task automatic predict_move(smq_in_t w);
    logic [39:0] ticks;
    logic [31:0] raw;
    logic [31:0] mag;
    smq_out_t o;
    int unsigned r;
    ticks = {8'd0, w.duration_us} * {32'd0, tick_rate};
    if (w.kind == KIND_LINE || w.kind == KIND_DWELL || w.kind == KIND_MARKER) begin
      if (wrap(wr_ptr) == rd_ptr) begin
        expected_words.push_back(status_word(ST_FULL));
      end else begin
        for (int a = 0; a < 3; a++) slot_axis[wr_ptr][a] = '0;
        if (w.kind == KIND_LINE) begin
          for (int a = 0; a < 3; a++) begin
            raw = (a == 0) ? w.steps_x_in : (a == 1) ? w.steps_y_in : w.steps_z_in;
            if (raw != 0) begin
              mag = raw[31] ? (32'd0 - raw) : raw;
              if (mag > 32'h7FFFFFFF) mag = 32'h7FFFFFFF;
              slot_axis[wr_ptr][a] = axis_timing(ticks, mag[30:0], raw[31]);
            end
          end
          slot_type[wr_ptr] = TYPE_LINE;
        end else if (w.kind == KIND_DWELL) begin
          slot_axis[wr_ptr][2] = axis_timing(ticks, 31'd1, 1'b0);
          slot_type[wr_ptr] = TYPE_DWELL;
        end else begin
          slot_type[wr_ptr] = TYPE_MARKER + {1'b0, w.marker_code};
        end
        wr_ptr = wrap(wr_ptr);
        expected_words.push_back(status_word(ST_OK));
      end
    end else if (w.kind == KIND_DEQUEUE) begin
      if (wr_ptr == rd_ptr) begin
        expected_words.push_back(status_word(ST_EMPTY));
      end else begin
        r = rd_ptr;
        rd_ptr = wrap(r);
        dequeues_ok++;
        for (int a = 0; a < 3; a++) begin
          o = status_word(ST_OK);
          o.last = (a == 2);
          o.entry_kind = slot_type[r];
          o.axis_index = a[1:0];
          o.axis_steps = slot_axis[r][a].steps;
          o.axis_direction = slot_axis[r][a].dir;
          o.axis_period = slot_axis[r][a].period;
          o.axis_postscale = slot_axis[r][a].post;
          expected_words.push_back(o);
        end
      end
    end else begin
      if (w.kind == KIND_FLUSH) rd_ptr = wr_ptr;
      expected_words.push_back(status_word(ST_OK));
    end
  endtask

  // driver: one word at a time, random gap before each
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_word <= '0;
      gap <= 0;
    end else if (start && !busy) begin
      predict_move(in_word);
      words_sent++;
      if (pending_words.size() > 0 && $urandom_range(0, 6) == 0 && gap == 0) begin
        in_word <= pending_words.pop_front();
      end else begin
        start <= 1'b0;
        gap <= $urandom_range(0, 6);
      end
    end else if (!start) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_words.size() > 0) begin
        in_word <= pending_words.pop_front();
        start <= 1'b1;
        gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    smq_out_t e;
    if (rst_n && out_valid) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        e = expected_words.pop_front();
        if (out_word !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", e, out_word);
        end
      end
    end
  end

  function automatic smq_in_t make_word(logic [2:0] k, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] d, logic [3:0] m);
    smq_in_t w;
    w.kind = k;
    w.steps_x_in = x;
    w.steps_y_in = y;
    w.steps_z_in = z;
    w.duration_us = d;
    w.marker_code = m;
    return w;
  endfunction

  function automatic logic [31:0] rand_steps();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom_range(1, 20);
      2: return -$urandom_range(1, 20);
      3: return 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic smq_in_t rand_word();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40)
      return make_word(KIND_LINE, rand_steps(), rand_steps(), rand_steps(),
                       $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000),
                       4'($urandom()));
    if (p < 50) return make_word(KIND_DWELL, $urandom(), $urandom(), $urandom(),
                                 $urandom(), 4'($urandom()));
    if (p < 60) return make_word(KIND_MARKER, $urandom(), $urandom(), $urandom(),
                                 $urandom(), 4'($urandom()));
    if (p < 92) return make_word(KIND_DEQUEUE, $urandom(), $urandom(), $urandom(),
                                 $urandom(), 4'($urandom()));
    if (p < 96) return make_word(KIND_FLUSH, $urandom(), $urandom(), $urandom(),
                                 $urandom(), 4'($urandom()));
    return make_word(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                     $urandom(), 4'($urandom()));
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_words.size() > 0 || start || expected_words.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("stepper_move_queue_precompute_tb NOT OK");
      $finish;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic set_rate(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tick_rate = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] rates[5];
    rates = '{8'd255, 8'd1, 8'd0, 8'd7, 8'd32};
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    tick_rate = 8'd32;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: empty dequeue, fill to full, overflow, extremes, drain, flush, unused kinds
    pending_words.push_back(make_word(KIND_DEQUEUE, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_LINE, 32'h7FFFFFFF, 32'h80000000, 32'h80000001,
                                      32'hFFFFFFFF, 0));
    pending_words.push_back(make_word(KIND_DWELL, 0, 0, 0, 32'hFFFFFFFF, 0));
    pending_words.push_back(make_word(KIND_MARKER, 0, 0, 0, 0, 4'hF));
    pending_words.push_back(make_word(KIND_MARKER, 0, 0, 0, 0, 4'h0));
    pending_words.push_back(make_word(KIND_LINE, 1, -1, 0, 1, 0));
    for (int i = 0; i < 4; i++)
      pending_words.push_back(make_word(KIND_DEQUEUE, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_LINE, 0, 0, 0, 100, 0));
    pending_words.push_back(make_word(KIND_LINE, 3, -5, 1, 0, 0));
    pending_words.push_back(make_word(KIND_FLUSH, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(KIND_DEQUEUE, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(3'd5, -1, -1, -1, 32'hFFFFFFFF, 4'hF));
    pending_words.push_back(make_word(3'd7, 0, 0, 0, 0, 0));
    drain();

    // random phases under several tick rates
    foreach (rates[i]) begin
      set_rate(rates[i]);
      for (int n = 0; n < 21; n++) pending_words.push_back(rand_word());
      drain();
    end

    $display("%0d command words sent, %0d result words checked, %0d moves dequeued",
             words_sent, words_seen, dequeues_ok);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("stepper_move_queue_precompute_tb OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("stepper_move_queue_precompute_tb NOT OK");
    end
    $finish;
  end
endmodule
